@@ rtl/core/slmh_pkg.sv @@
`timescale 1ns / 1ps
package slmh_pkg;

	// Lattice geometry
	localparam int DIMENSIONS = 2;
	localparam int SIDE_LOG2  = 6;
	localparam int VOL_BITS   = DIMENSIONS * SIDE_LOG2;
	localparam int VOLUME     = 1 << VOL_BITS;
	localparam int SIDE_MASK  = (1 << SIDE_LOG2) - 1;

	// Field widths
	localparam int SITE_W     = 12;
	localparam int RND_W      = 32;
	localparam int WEIGHT_W   = 33;
	localparam int SUM_W      = 4;

	// Configuration space
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = WEIGHT_W;
	localparam int WEIGHT_COUNT = 7;
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0 = 3'd1;

	localparam logic MODE_METROPOLIS = 1'b0;
	localparam logic MODE_HEATBATH   = 1'b1;

	// Read sequence: 2*DIM neighbours, then the site itself
	localparam int RD_W = $clog2(2 * DIMENSIONS + 1);
	localparam logic [RD_W-1:0] RD_LAST = RD_W'(2 * DIMENSIONS);

	typedef logic signed [SUM_W-1:0] sum_t;
	localparam sum_t DIM_S = SUM_W'(DIMENSIONS);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic            clr_wr;
		logic            load;
		logic            rd_issue;
		logic [RD_W-1:0] rd_sel;
		logic            commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_busy;
	} status_t;

	function automatic logic [VOL_BITS-1:0] slmh_site_idx(logic [SITE_W-1:0] s);
		logic [31:0] ext;
		ext = 32'(s);
		return ext[VOL_BITS-1:0];
	endfunction

	// Even sel: coordinate sel/2 plus one; odd sel: minus one. Wraps on the side.
	function automatic logic [VOL_BITS-1:0] slmh_neighbour(logic [VOL_BITS-1:0] idx,
			logic [RD_W-1:0] sel);
		int unsigned          sh;
		logic [SIDE_LOG2-1:0] c;
		logic [SIDE_LOG2-1:0] nc;
		sh = int'(sel >> 1) * SIDE_LOG2;
		c  = SIDE_LOG2'(idx >> sh);
		nc = sel[0] ? c - 1'b1 : c + 1'b1;
		return (idx & ~(VOL_BITS'(SIDE_MASK) << sh)) | (VOL_BITS'(nc) << sh);
	endfunction

endpackage

@@ rtl/core/slmh_if.sv @@
`timescale 1ns / 1ps
interface slmh_in_if;
	logic                        valid;
	logic                        ready;
	logic [slmh_pkg::SITE_W-1:0] site;
	logic [slmh_pkg::RND_W-1:0]  random_fraction;

	modport source (output valid, site, random_fraction, input ready);
	modport sink (input valid, site, random_fraction, output ready);
endinterface

interface slmh_out_if;
	logic                 valid;
	logic                 ready;
	logic                 flipped;
	logic                 new_spin;
	logic signed [slmh_pkg::SUM_W-1:0] neighbour_sum;

	modport source (output valid, flipped, new_spin, neighbour_sum, input ready);
	modport sink (input valid, flipped, new_spin, neighbour_sum, output ready);
endinterface

@@ rtl/core/slmh_ctrl.sv @@
`timescale 1ns / 1ps
module slmh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  slmh_pkg::status_t st,
	output slmh_pkg::cmd_t    cmd
);
	import slmh_pkg::*;

	state_t          state_q, state_d;
	logic [RD_W-1:0] rd_cnt_q, rd_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			rd_cnt_q <= '0;
		end else begin
			state_q  <= state_d;
			rd_cnt_q <= rd_cnt_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		rd_cnt_d     = rd_cnt_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.rd_sel   = rd_cnt_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					rd_cnt_d = '0;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				if (rd_cnt_q == RD_LAST) begin
					state_d = S_DECIDE;
				end else begin
					rd_cnt_d = rd_cnt_q + 1'b1;
				end
			end
			S_DECIDE: begin
				if (!st.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> (cmd.rd_sel <= RD_LAST))
		else $error("read select beyond site slot");
	a_commit_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (state_q == S_DECIDE) && !st.out_busy)
		else $error("commit outside decide or into busy output");
	a_load_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.rd_issue && (cmd.rd_sel == '0))
		else $error("read sequence did not start after load");

endmodule

@@ rtl/core/slmh_datapath.sv @@
`timescale 1ns / 1ps
module slmh_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [slmh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slmh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [slmh_pkg::SITE_W-1:0]     site,
	input  logic [slmh_pkg::RND_W-1:0]      random_fraction,
	input  slmh_pkg::cmd_t                  cmd,
	output slmh_pkg::status_t               st,
	slmh_out_if.source                      result
);
	import slmh_pkg::*;

	// Configuration
	logic                mode_q;
	logic [WEIGHT_W-1:0] weight_q [WEIGHT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_METROPOLIS;
			for (int i = 0; i < WEIGHT_COUNT; i++) begin
				weight_q[i] <= {1'b1, {(WEIGHT_W-1){1'b0}}};
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[0];
			end else begin
				weight_q[cfg_index - REG_WEIGHT0] <= cfg_data;
			end
		end
	end

	// Current item
	logic [VOL_BITS-1:0] site_q;
	logic [RND_W-1:0]    rnd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			site_q <= slmh_site_idx(site);
			rnd_q  <= random_fraction;
		end
	end

	// Spin memory, one read and one write port
	logic                spin_mem [VOLUME];
	logic [VOL_BITS-1:0] rd_addr;
	logic [VOL_BITS-1:0] wr_addr;
	logic                wr_en;
	logic                wr_data;
	logic                rd_data_q;
	logic                new_spin;

	assign rd_addr = (cmd.rd_sel == RD_LAST) ? site_q : slmh_neighbour(site_q, cmd.rd_sel);
	assign wr_en   = cmd.clr_wr | cmd.commit;

	logic [VOL_BITS-1:0] clr_cnt_q;
	assign wr_addr = cmd.clr_wr ? clr_cnt_q : site_q;
	assign wr_data = cmd.clr_wr ? 1'b1 : new_spin;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			spin_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= spin_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end
	assign st.clr_last = &clr_cnt_q;

	// Read-data tracking and neighbour accumulation
	logic rd_pend_s1;
	logic rd_nbr_s1;
	sum_t sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			rd_nbr_s1  <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.rd_issue;
			rd_nbr_s1  <= cmd.rd_sel != RD_LAST;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= '0;
		end else if (rd_pend_s1 && rd_nbr_s1) begin
			sum_q <= sum_q + (rd_data_q ? sum_t'(1) : sum_t'(-1));
		end
	end

	// Decision; rd_data_q holds the old spin here
	sum_t                k_val;
	sum_t                idx_m;
	sum_t                idx_h;
	logic [2:0]          widx;
	logic [WEIGHT_W-1:0] w_sel;
	logic [WEIGHT_W-1:0] rnd_x;
	logic                metro_flip;

	always_comb begin
		k_val = rd_data_q ? sum_q : -sum_q;
		idx_m = (k_val >>> 1) + DIM_S;
		idx_h = (sum_q >>> 1) + DIM_S;
		widx  = (mode_q == MODE_HEATBATH) ? idx_h[2:0] : idx_m[2:0];
		w_sel = (int'(widx) < WEIGHT_COUNT) ? weight_q[widx] : '0;
		rnd_x = {1'b0, rnd_q};
		metro_flip = (k_val <= sum_t'(0)) || (rnd_x <= w_sel);
		if (mode_q == MODE_HEATBATH) begin
			new_spin = rnd_x < w_sel;
		end else begin
			new_spin = rd_data_q ^ metro_flip;
		end
	end

	// Output register
	logic out_valid_q;
	logic flipped_q;
	logic new_spin_q;
	sum_t sum_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			flipped_q  <= new_spin ^ rd_data_q;
			new_spin_q <= new_spin;
			sum_out_q  <= sum_q;
		end
	end

	assign st.out_busy          = out_valid_q && !result.ready;
	assign result.valid         = out_valid_q;
	assign result.flipped       = flipped_q;
	assign result.new_spin      = new_spin_q;
	assign result.neighbour_sum = sum_out_q;

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && cmd.clr_wr))
		else $error("clear and commit write together");
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !result.ready))
		else $error("commit would overwrite a waiting word");
	a_read_track: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |=> rd_pend_s1)
		else $error("read tracking lost an issue");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> result.valid)
		else $error("committed word not presented");

endmodule

@@ rtl/core/spin_lattice_metropolis_heatbath.sv @@
`timescale 1ns / 1ps
// Each update word runs a read sequence over the single read port of the spin memory
//   (2*DIMENSIONS neighbour reads, one site read), then a decide step that registers the
//   result once the output is free; the next update word is taken only after that.
// Reset: config registers return to Metropolis with every weight at 2^32; then a clearing
//   pass writes all VOLUME sites (4096 at the defaults) to +1; no update is taken.
module spin_lattice_metropolis_heatbath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [slmh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slmh_pkg::CFG_DATA_W-1:0] cfg_data,
	slmh_in_if.sink                         update,
	slmh_out_if.source                      result
);
	import slmh_pkg::*;

	// Controller sequences clear, read, and decide; the datapath holds
	// the spin memory, the accumulator, and the output register.
	cmd_t    cmd;
	status_t st;
	logic    in_ready;

	slmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (update.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// An update word is accepted only in idle; the previous result may still be waiting.
	assign update.ready = in_ready;

	slmh_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.site            (update.site),
		.random_fraction (update.random_fraction),
		.cmd             (cmd),
		.st              (st),
		.result          (result)
	);

endmodule

@@ tb/sv/spin_lattice_metropolis_heatbath_test.sv @@
`timescale 1ns / 1ps
module spin_lattice_metropolis_heatbath_test;
	import slmh_pkg::*;

	// One update word as the sender queues it
	typedef struct packed {
		logic [SITE_W-1:0] site;
		logic [RND_W-1:0]  fraction;
	} update_word_t;

	// One result word as the block should return it
	typedef struct packed {
		logic flipped;
		logic new_spin;
		sum_t neighbour_sum;
	} spin_result_t;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(64'd1 << RND_W); // 2^32
	localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = '1;                        // above 2^32
	localparam int LONG_HOLD_CYCLES = 100;
	localparam int DRAIN_CYCLES     = 2 * DIMENSIONS + 4;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	slmh_in_if  update ();
	slmh_out_if result ();

	spin_lattice_metropolis_heatbath i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.update    (update),
		.result    (result)
	);

	// Shadow copy of the lattice and the registers
	logic [VOLUME-1:0]   lattice_spin;
	logic                cfg_mode;
	logic [WEIGHT_W-1:0] weight_table [WEIGHT_COUNT];

	update_word_t pending_words [$];
	spin_result_t expected_results [$];
	int           mismatch_count;

	// Sender / receiver pacing
	int send_gap;
	int send_calm;
	bit sender_eager;
	int recv_stall;
	int recv_calm;
	int hold_request;
	int hold_taken;
	update_word_t next_word;
	spin_result_t want;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Single-site update: neighbour sum with periodic wrap, then the
	// Metropolis or heat-bath rule on the shadow lattice.
	function automatic spin_result_t predict_site_update(logic [SITE_W-1:0] site_in,
			logic [RND_W-1:0] fraction);
		logic [VOL_BITS-1:0]  here;
		logic [VOL_BITS-1:0]  there;
		logic [SIDE_LOG2-1:0] coord;
		logic                 spin_was;
		logic                 spin_now;
		int                   field_sum;
		int                   energy;
		int                   w_idx;
		int                   d;
		spin_result_t         res;
		here      = VOL_BITS'(site_in);
		field_sum = 0;
		for (d = 0; d < DIMENSIONS; d++) begin
			coord = here[d*SIDE_LOG2 +: SIDE_LOG2];
			there = here;
			there[d*SIDE_LOG2 +: SIDE_LOG2] = coord + 1'b1;
			field_sum += lattice_spin[there] ? 1 : -1;
			// on a side of two this lands on the same site again, counted twice
			there[d*SIDE_LOG2 +: SIDE_LOG2] = coord - 1'b1;
			field_sum += lattice_spin[there] ? 1 : -1;
		end
		spin_was = lattice_spin[here];
		if (cfg_mode == MODE_METROPOLIS) begin
			energy = spin_was ? field_sum : -field_sum;
			w_idx  = energy / 2 + DIMENSIONS;
			// energy not raised: always flip; else compare against the table
			if (energy <= 0 ||
					(w_idx < WEIGHT_COUNT && {1'b0, fraction} <= weight_table[w_idx])) begin
				spin_now = ~spin_was;
			end else begin
				spin_now = spin_was;
			end
		end else begin
			w_idx    = field_sum / 2 + DIMENSIONS;
			spin_now = (w_idx >= 0 && w_idx < WEIGHT_COUNT &&
				{1'b0, fraction} < weight_table[w_idx]);
		end
		lattice_spin[here] = spin_now;
		res.flipped       = spin_now != spin_was;
		res.new_spin      = spin_now;
		res.neighbour_sum = sum_t'(field_sum);
		return res;
	endfunction

	// Sender: offers queued words, random gap after each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update.valid           <= 1'b0;
			update.site            <= '0;
			update.random_fraction <= '0;
			send_gap               <= 0;
		end else begin
			if (update.valid && update.ready) begin
				expected_results.push_back(
					predict_site_update(update.site, update.random_fraction));
			end
			if (!update.valid || update.ready) begin
				if (send_gap > 0) begin
					send_gap     <= send_gap - 1;
					update.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					next_word = pending_words.pop_front();
					update.valid           <= 1'b1;
					update.site            <= next_word.site;
					update.random_fraction <= next_word.fraction;
					if (send_calm > 0)
						send_calm--;
					else if ($urandom_range(0, 15) == 0)
						send_calm = $urandom_range(8, 30);
					send_gap <= (sender_eager || send_calm > 0) ? 0 : $urandom_range(0, 15);
				end else begin
					update.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every result word, random stall after each one,
	// plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result word with nothing expected", $time);
				end else begin
					want = expected_results.pop_front();
					if (result.flipped !== want.flipped) begin
						mismatch_count++;
						$display("%0t: flipped expected %0d got %0d", $time,
							want.flipped, result.flipped);
					end
					if (result.new_spin !== want.new_spin) begin
						mismatch_count++;
						$display("%0t: new_spin expected %0d got %0d", $time,
							want.new_spin, result.new_spin);
					end
					if (result.neighbour_sum !== want.neighbour_sum) begin
						mismatch_count++;
						$display("%0t: neighbour_sum expected %0d got %0d", $time,
							want.neighbour_sum, result.neighbour_sum);
					end
				end
				if (recv_calm > 0)
					recv_calm--;
				else if ($urandom_range(0, 15) == 0)
					recv_calm = $urandom_range(8, 30);
				recv_stall = (recv_calm > 0) ? 0 : $urandom_range(0, 15);
			end
			if (hold_taken != hold_request) begin
				hold_taken = hold_request;
				recv_stall = LONG_HOLD_CYCLES;
			end
			if (recv_stall > 0) begin
				result.ready <= 1'b0;
				recv_stall--;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic offer(logic [SITE_W-1:0] site, logic [RND_W-1:0] fraction);
		update_word_t w;
		w.site     = site;
		w.fraction = fraction;
		pending_words.push_back(w);
	endtask

	// Wait until every queued word went in and every result came back
	task automatic settle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || update.valid || expected_results.size() != 0);
	endtask

	// Register write; only called while the block is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (index == REG_MODE)
			cfg_mode = data[0];
		else
			weight_table[int'(index) - int'(REG_WEIGHT0)] = data;
	endtask

	// Random words: mostly a small patch of sites so spins get mixed up,
	// some on the lattice faces, some anywhere. Fractions often sit right
	// at a table weight to hit the < / <= boundary.
	task automatic run_random_phase(int n_words, bit wrap_corner, int pause_at);
		logic [SITE_W-1:0]    s;
		logic [RND_W-1:0]     f;
		logic [SIDE_LOG2-1:0] corner [DIMENSIONS];
		int                   d;
		int                   j;
		for (d = 0; d < DIMENSIONS; d++)
			corner[d] = wrap_corner ? SIDE_LOG2'(SIDE_MASK - 1) : SIDE_LOG2'($urandom);
		for (j = 0; j < n_words; j++) begin
			if (j == pause_at)
				settle();
			s = SITE_W'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					for (d = 0; d < DIMENSIONS; d++)
						s[d*SIDE_LOG2 +: SIDE_LOG2] =
							corner[d] + SIDE_LOG2'($urandom_range(0, 3));
				end
				6, 7: begin
					d = $urandom_range(0, DIMENSIONS - 1);
					s[d*SIDE_LOG2 +: SIDE_LOG2] =
						$urandom_range(0, 1) ? SIDE_LOG2'(SIDE_MASK) : '0;
				end
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0:       f = '0;
				1:       f = '1;
				2, 3:    f = RND_W'(weight_table[$urandom_range(0, 2 * DIMENSIONS)]) +
					RND_W'($urandom_range(0, 2)) - RND_W'(1);
				default: f = $urandom;
			endcase
			offer(s, f);
		end
	endtask

	initial begin
		logic [WEIGHT_W-1:0] w;
		int                  p;
		int                  i;
		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_index              = '0;
		cfg_data               = '0;
		update.valid           = 1'b0;
		update.site            = '0;
		update.random_fraction = '0;
		result.ready           = 1'b0;
		mismatch_count         = 0;
		send_calm              = 0;
		recv_calm              = 0;
		sender_eager           = 1'b0;
		hold_request           = 0;
		hold_taken             = 0;
		lattice_spin           = '1;
		cfg_mode               = MODE_METROPOLIS;
		for (i = 0; i < WEIGHT_COUNT; i++)
			weight_table[i] = WEIGHT_ONE;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: every weight at 2^32, so Metropolis always flips.
		// Corners of the index range, both ends of the fraction, and a site
		// whose energy is already negative.
		offer(SITE_W'(0), RND_W'(0));
		offer(SITE_W'(1), '1);
		offer('1, '1);
		offer(SITE_W'(0), RND_W'(123));
		settle();

		// Metropolis against hard thresholds: zero, exact half, above 2^32
		write_reg(REG_MODE, CFG_DATA_W'(MODE_METROPOLIS));
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 0), '0);
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 1), CFG_DATA_W'(1));
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 2), WEIGHT_TOP);
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 3), CFG_DATA_W'(32'h8000_0000));
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 4), '0);
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 5), WEIGHT_ONE);
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 6), '0);
		offer(SITE_W'(2080), RND_W'(0));           // fraction equal to zero weight
		offer(SITE_W'(100), RND_W'(1));            // just above it: stays
		offer(SITE_W'(2), RND_W'(32'h8000_0000));  // one unlike neighbour, at the weight
		offer(SITE_W'(65), RND_W'(32'h8000_0001)); // one past the weight
		settle();

		// Heat bath: carve a cross of down spins, then update its center
		write_reg(REG_MODE, CFG_DATA_W'(MODE_HEATBATH));
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 0), WEIGHT_TOP);
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 1), '0);
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 2), CFG_DATA_W'(32'hFFFF_FFFF));
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 3), CFG_DATA_W'(1));
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 4), '0);
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 5), '0);
		write_reg(CFG_IDX_W'(REG_WEIGHT0 + 6), WEIGHT_TOP);
		offer(SITE_W'(201), $urandom);
		offer(SITE_W'(199), $urandom);
		offer(SITE_W'(264), $urandom);
		offer(SITE_W'(136), $urandom);
		offer(SITE_W'(200), '1);       // all neighbours down, weight above 2^32
		offer(SITE_W'(1), RND_W'(0));  // strict compare, just under the weight
		offer(SITE_W'(1), RND_W'(1));  // equal to the weight: goes down
		offer(SITE_W'(201), '1);
		settle();

		// Random phases, alternating the update rule, fresh weights each time
		for (p = 0; p < 7; p++) begin
			write_reg(REG_MODE,
				CFG_DATA_W'((p % 2 == 1) ? MODE_HEATBATH : MODE_METROPOLIS));
			for (i = 0; i < WEIGHT_COUNT; i++) begin
				case ($urandom_range(0, 7))
					0:       w = '0;
					1:       w = WEIGHT_ONE;
					2:       w = WEIGHT_TOP;
					default: w = {1'b0, 32'($urandom)};
				endcase
				write_reg(CFG_IDX_W'(REG_WEIGHT0 + i), w);
			end
			if (p == 1) begin
				// receiver holds off while the sender keeps pushing
				sender_eager = 1'b1;
				hold_request++;
			end
			run_random_phase(100, p % 2 == 1, (p == 3) ? 50 : -1);
			settle();
			sender_eager = 1'b0;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog; covers the clearing pass after reset many times over
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
